// ===== rtl/plti_pkg.sv =====
package plti_pkg;

    // table size default
    localparam int DEF_MAX_POINTS = 64;

    // field widths
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int VAL_W = 32;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 40;

    // point_count after reset
    localparam logic [CNT_W-1:0] POINT_COUNT_RST = 7'd2;

    // request kind carried in tuser
    localparam logic ACT_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic wr;
        logic start;
        logic first;
        logic adv;
        logic diff;
        logic mul;
        logic div_start;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic hit;
        logic at_last;
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/plti_div.sv =====
module plti_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [2*plti_pkg::VAL_W-1:0]   i_dividend,
    input  logic [plti_pkg::VAL_W-1:0]     i_divisor,
    output logic                           o_busy,
    output logic [2*plti_pkg::VAL_W-1:0]   o_quo
);
    import plti_pkg::*;

    localparam int DIVD_W       = 2 * VAL_W;
    localparam int BITS_PER_CYC = 2;
    localparam int STEPS        = DIVD_W / BITS_PER_CYC;
    localparam int CTR_W        = $clog2(STEPS + 1);

    logic [CTR_W-1:0]  r_cnt;
    logic [VAL_W-1:0]  r_rem, n_rem;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [VAL_W-1:0]  r_dsor;
    logic [VAL_W:0]    sh;

    // two restoring steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        sh    = '0;
        for (int k = 0; k < BITS_PER_CYC; k++) begin
            sh = {n_rem, n_quo[DIVD_W-1]};
            if (sh >= {1'b0, r_dsor}) begin
                sh    = sh - {1'b0, r_dsor};
                n_quo = {n_quo[DIVD_W-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[DIVD_W-2:0], 1'b0};
            end
            n_rem = sh[VAL_W-1:0];
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CTR_W'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CTR_W'(1);
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dsor <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

// ===== rtl/plti_dpath.sv =====
module plti_dpath #(
    parameter int MAX_POINTS = plti_pkg::DEF_MAX_POINTS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [plti_pkg::CNT_W-1:0]      i_cfg_wr_data,
    input  logic [plti_pkg::S_DATA_W-1:0]   i_s_data,
    input  plti_pkg::t_cmd                  i_cmd,
    output plti_pkg::t_stat                 o_stat,
    input  logic                            i_m_ready,
    output logic                            o_m_valid,
    output logic [plti_pkg::M_DATA_W-1:0]   o_m_data
);
    import plti_pkg::*;

    localparam int IW   = $clog2(MAX_POINTS);
    localparam int XW   = (IW > IDX_W) ? IW : IDX_W;
    localparam int CW   = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
    localparam int ENT_W = 2 * VAL_W;

    // saturation bounds in the widened sum
    localparam logic signed [VAL_W+4:0] SUM_HI = $signed({{5{1'b0}}, 1'b0, {(VAL_W-1){1'b1}}});
    localparam logic signed [VAL_W+4:0] SUM_LO = $signed({{5{1'b1}}, 1'b1, {(VAL_W-1){1'b0}}});

    // input fields
    logic [IDX_W-1:0] in_idx;
    logic [VAL_W-1:0] in_ptime, in_pval, in_qtime;

    assign in_idx   = i_s_data[IDX_W-1:0];
    assign in_ptime = i_s_data[IDX_W +: VAL_W];
    assign in_pval  = i_s_data[IDX_W+VAL_W +: VAL_W];
    assign in_qtime = i_s_data[IDX_W+2*VAL_W +: VAL_W];

    logic [CNT_W-1:0] r_point_count;
    logic [IW-1:0]    r_last, r_idx;
    logic [VAL_W-1:0] r_tq;
    logic [ENT_W-1:0] r_mem [MAX_POINTS];
    logic [ENT_W-1:0] r_rdata, r_prev;
    logic [VAL_W-1:0] r_dv_mag, r_dq_mag, r_dt_mag;
    logic             r_neg, r_dt_zero;
    logic [ENT_W-1:0] r_prod;
    logic             r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= POINT_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            r_point_count <= i_cfg_wr_data;
        end
    end

    // clamp point count, last upper index
    logic [CW-1:0] pc_x, n_eff, last_x;

    always_comb begin
        pc_x = CW'(r_point_count);
        if (pc_x < CW'(2)) begin
            n_eff = CW'(2);
        end else if (pc_x > CW'(MAX_POINTS)) begin
            n_eff = CW'(MAX_POINTS);
        end else begin
            n_eff = pc_x;
        end
        last_x = n_eff - CW'(1);
    end

    // load address check
    logic [XW-1:0] wr_idx_x;
    logic          wr_ok;
    logic [IW-1:0] wr_addr, rd_addr;

    assign wr_idx_x = XW'(in_idx);
    assign wr_ok    = ({1'b0, wr_idx_x} < (XW+1)'(MAX_POINTS));
    assign wr_addr  = wr_idx_x[IW-1:0];

    // table read address
    always_comb begin
        if (i_cmd.start) begin
            rd_addr = '0;
        end else if (i_cmd.adv) begin
            rd_addr = r_idx + IW'(1);
        end else begin
            rd_addr = r_idx;
        end
    end

    // point table, time in the upper half
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_ok) begin
            r_mem[wr_addr] <= {in_ptime, in_pval};
        end
        r_rdata <= r_mem[rd_addr];
    end

    // segment search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_tq   <= in_qtime;
            r_last <= last_x[IW-1:0];
            r_idx  <= IW'(1);
        end else if (i_cmd.adv) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.first || i_cmd.adv) begin
            r_prev <= r_rdata;
        end
    end

    // segment ends: lower in r_prev, upper in r_rdata
    logic [VAL_W-1:0] lo_t, lo_v, hi_t, hi_v;
    logic [VAL_W:0]   dv, dq, dt, dv_abs, dq_abs, dt_abs;

    assign lo_t = r_prev[ENT_W-1:VAL_W];
    assign lo_v = r_prev[VAL_W-1:0];
    assign hi_t = r_rdata[ENT_W-1:VAL_W];
    assign hi_v = r_rdata[VAL_W-1:0];

    assign dv = {hi_v[VAL_W-1], hi_v} - {lo_v[VAL_W-1], lo_v};
    assign dq = {r_tq[VAL_W-1], r_tq} - {lo_t[VAL_W-1], lo_t};
    assign dt = {hi_t[VAL_W-1], hi_t} - {lo_t[VAL_W-1], lo_t};

    assign dv_abs = dv[VAL_W] ? -dv : dv;
    assign dq_abs = dq[VAL_W] ? -dq : dq;
    assign dt_abs = dt[VAL_W] ? -dt : dt;

    // differences, magnitudes and sign
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            r_dv_mag  <= dv_abs[VAL_W-1:0];
            r_dq_mag  <= dq_abs[VAL_W-1:0];
            r_dt_mag  <= dt_abs[VAL_W-1:0];
            r_neg     <= dv[VAL_W] ^ dq[VAL_W] ^ dt[VAL_W];
            r_dt_zero <= (dt == '0);
        end
        if (i_cmd.mul) begin
            r_prod <= ENT_W'(r_dv_mag) * ENT_W'(r_dq_mag);
        end
    end

    // serial divide of product by segment length
    logic             div_busy;
    logic [ENT_W-1:0] quo;

    plti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_dt_mag),
        .o_busy     (div_busy),
        .o_quo      (quo)
    );

    // clamp quotient, add to lower value, saturate
    logic [VAL_W+2:0]         q35;
    logic signed [VAL_W+4:0]  lo_x, sum;
    logic [VAL_W-1:0]         res;
    logic [XW-1:0]            seg_x;

    always_comb begin
        if (|quo[ENT_W-1:VAL_W+2]) begin
            q35 = {1'b1, {(VAL_W+2){1'b0}}};
        end else begin
            q35 = {1'b0, quo[VAL_W+1:0]};
        end
        lo_x = (VAL_W+5)'($signed(lo_v));
        if (r_neg) begin
            sum = lo_x - $signed({2'b00, q35});
        end else begin
            sum = lo_x + $signed({2'b00, q35});
        end
        if (r_dt_zero) begin
            res = lo_v;
        end else if (sum > SUM_HI) begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (sum < SUM_LO) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = sum[VAL_W-1:0];
        end
        seg_x = XW'(r_idx);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_data <= {{(M_DATA_W-IDX_W-VAL_W){1'b0}}, seg_x[IDX_W-1:0], res};
        end
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;

    // status
    assign o_stat.hit      = ($signed(r_tq) <= $signed(hi_t));
    assign o_stat.at_last  = (r_idx == r_last);
    assign o_stat.div_busy = div_busy;
    assign o_stat.out_free = !r_m_valid || i_m_ready;

`ifndef SYNTH
    // search never steps past the last upper index
    a_adv_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.adv |-> (r_idx != r_last))
        else $error("segment search stepped past last point");

    // a result is loaded only when the output register is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_m_valid || i_m_ready))
        else $error("result overwrote a pending result");

    // differences follow a finished search
    a_diff_after_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.diff |-> $past(o_stat.hit || o_stat.at_last))
        else $error("segment taken before search ended");

    // divider runs once the product is ready
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> $past(i_cmd.mul))
        else $error("divide started without a fresh product");
`endif

endmodule

// ===== rtl/plti_ctrl.sv =====
module plti_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    input  logic              i_action,
    output logic              o_s_ready,
    input  plti_pkg::t_stat   i_stat,
    output plti_pkg::t_cmd    o_cmd
);
    import plti_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RD0    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DIFF   = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_DSTART = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_FIN    = 3'd7;

    logic [2:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    if (i_action == ACT_QUERY) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_RD0;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            ST_RD0: begin
                o_cmd.first = 1'b1;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.hit || i_stat.at_last) begin
                    n_state = ST_DIFF;
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DSTART;
            end
            ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/piecewise_linear_table_interp.sv =====
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: load point or query, tuser: action
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: interpolated value, segment index
// cfg       in   i_cfg_wr_en                    i_cfg_wr_data: point_count
//
// a load request is written as it is accepted; a query scans k table entries
// with the one-read-per-cycle search (1 to n-1, n = point_count held to 2..MAX_POINTS),
// then takes differences, multiplies and runs the 2-bit-per-cycle divider
// sync active-low reset clears controller, output valid, point_count (2), not the table
// a finished result waits in the output register while the next request is taken
// a query stalls only in its last cycle if that register is still full
module piecewise_linear_table_interp #(
    parameter int MAX_POINTS = plti_pkg::DEF_MAX_POINTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [plti_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // point_index, point_time, point_value, query_time, zero pad
    input  logic [plti_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // action
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // interp_value, segment_upper, zero pad
    output logic [plti_pkg::M_DATA_W-1:0]  m_axis_tdata
);
    import plti_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    plti_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_action  (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    // table, arithmetic and output register
    plti_dpath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_data      (s_axis_tdata),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_m_ready     (m_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_m_data      (m_axis_tdata)
    );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import plti_pkg::*;

    localparam int TABLE_DEPTH = DEF_MAX_POINTS;
    localparam logic ACT_LOAD = 1'b0;
    localparam int IDLE_PCT = 37;
    localparam int BURST_FROM = 300;
    localparam int BURST_TO = 520;
    localparam int LOAD_SETTLE = 10;
    localparam int DRAIN_CYCLES = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS = 97;
    localparam int PHASE_NUM = 11;
    localparam longint VAL_MAX = 64'sd2147483647;
    localparam longint VAL_MIN = -64'sd2147483648;
    localparam longint ONE = 64'sd65536;

    typedef struct {
        logic             act;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] ptime;
        logic [VAL_W-1:0] pval;
        logic [VAL_W-1:0] qtime;
    } t_point_req;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] seg;
    } t_interp_res;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]    i_cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                s_axis_tuser = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;

    // predictor state, updated as requests are accepted
    logic [VAL_W-1:0] time_tab [TABLE_DEPTH];
    logic [VAL_W-1:0] value_tab [TABLE_DEPTH];
    logic [CNT_W-1:0] active_count = POINT_COUNT_RST;

    // table as the generator has planned it, for picking query times
    logic [VAL_W-1:0] plan_time [TABLE_DEPTH];

    t_point_req  pending_reqs[$];
    t_interp_res expected_results[$];
    t_point_req  live_req;
    bit          req_open = 1'b0;
    int          accepted_reqs = 0;
    int          err_count = 0;
    int          quiet_cycles = 0;

    piecewise_linear_table_interp dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint sat32(longint x);
        if (x > VAL_MAX) begin
            return VAL_MAX;
        end
        if (x < VAL_MIN) begin
            return VAL_MIN;
        end
        return x;
    endfunction

    function automatic longint unsigned magnitude(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic int eff_count(int c);
        if (c < 2) begin
            return 2;
        end
        if (c > TABLE_DEPTH) begin
            return TABLE_DEPTH;
        end
        return c;
    endfunction

    function automatic longint rand32();
        return longint'($signed($urandom()));
    endfunction

    // segment search and linear interpolation with saturation
    function automatic t_interp_res interp_eval(logic [VAL_W-1:0] tq);
        t_interp_res      r;
        int               n;
        int               i;
        longint           lo_v;
        longint           dv;
        longint           dq;
        longint           dt;
        longint           sum;
        longint unsigned  quo;
        bit               neg;
        n = eff_count(active_count);
        i = 1;
        while (i < n && $signed(tq) > $signed(time_tab[i])) begin
            i++;
        end
        if (i == n) begin
            i = n - 1;
        end
        lo_v = longint'($signed(value_tab[i - 1]));
        dv = longint'($signed(value_tab[i])) - lo_v;
        dq = longint'($signed(tq)) - longint'($signed(time_tab[i - 1]));
        dt = longint'($signed(time_tab[i])) - longint'($signed(time_tab[i - 1]));
        if (dt == 0) begin
            r.value = value_tab[i - 1];
        end else begin
            neg = ((dv < 0) != (dq < 0)) != (dt < 0);
            quo = (magnitude(dv) * magnitude(dq)) / magnitude(dt);
            if (quo > (64'd1 << 34)) begin
                quo = 64'd1 << 34;
            end
            sum = neg ? lo_v - longint'(quo) : lo_v + longint'(quo);
            sum = sat32(sum);
            r.value = sum[VAL_W-1:0];
        end
        r.seg = i[IDX_W-1:0];
        return r;
    endfunction

    task automatic apply_request(t_point_req r);
        if (r.act == ACT_LOAD) begin
            time_tab[r.idx] = r.ptime;
            value_tab[r.idx] = r.pval;
        end else begin
            expected_results.push_back(interp_eval(r.qtime));
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic bit idle_now();
        if (accepted_reqs >= BURST_FROM && accepted_reqs < BURST_TO) begin
            return 1'b0;
        end
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(live_req);
                accepted_reqs++;
                req_open = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() > 0 && !idle_now()) begin
                    live_req = pending_reqs.pop_front();
                    req_open = 1'b1;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= live_req.act;
                    s_axis_tdata <= {2'b00, live_req.qtime, live_req.pval,
                                     live_req.ptime, live_req.idx};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_interp_res want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: %h", m_axis_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[VAL_W-1:0] !== want.value) begin
                        report_mismatch($sformatf("interp_value got %h want %h",
                                                  m_axis_tdata[VAL_W-1:0], want.value));
                    end
                    if (m_axis_tdata[VAL_W+IDX_W-1:VAL_W] !== want.seg) begin
                        report_mismatch($sformatf("segment_upper got %0d want %0d",
                                                  m_axis_tdata[VAL_W+IDX_W-1:VAL_W],
                                                  want.seg));
                    end
                end
            end
            m_axis_tready <= !idle_now();
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL piecewise_linear_table_interp");
                $finish;
            end
        end
    end

    task automatic push_load(int idx, longint t, longint v);
        t_point_req r;
        t = sat32(t);
        v = sat32(v);
        r.act = ACT_LOAD;
        r.idx = idx[IDX_W-1:0];
        r.ptime = t[VAL_W-1:0];
        r.pval = v[VAL_W-1:0];
        r.qtime = $urandom();
        plan_time[idx] = t[VAL_W-1:0];
        pending_reqs.push_back(r);
    endtask

    task automatic push_query(longint t);
        t_point_req r;
        t = sat32(t);
        r.act = ACT_QUERY;
        r.idx = $urandom();
        r.ptime = $urandom();
        r.pval = $urandom();
        r.qtime = t[VAL_W-1:0];
        pending_reqs.push_back(r);
    endtask

    // wait until no request is pending, open or awaiting its result
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req_open || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(int c);
        wait_idle();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= c[CNT_W-1:0];
        active_count = c[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // query time near, on or beyond the planned points
    function automatic longint pick_query(int n);
        int     k;
        longint lo;
        longint hi;
        longint t;
        k = $urandom_range(n - 1, 1);
        lo = $signed(plan_time[k - 1]);
        hi = $signed(plan_time[k]);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: t = lo + ((hi - lo) * longint'($urandom_range(65536))) / 65536;
            5: t = hi;
            6: t = $urandom_range(1) ? hi + 1 : lo - 1;
            7: t = rand32();
            8: t = $urandom_range(1) ? VAL_MAX : VAL_MIN;
            default: t = longint'($signed(plan_time[n - 1]))
                         + longint'($urandom_range(1 << 20));
        endcase
        return t;
    endfunction

    // ascending table of n points with random spacing
    task automatic push_sorted_table(int n);
        int          k;
        int unsigned step_max;
        longint      t;
        longint      v;
        case ($urandom_range(5))
            0: step_max = 1;
            1: step_max = 1 << 8;
            2: step_max = 1 << 16;
            3: step_max = 1 << 20;
            4: step_max = 1 << 24;
            default: step_max = 1 << 28;
        endcase
        t = $urandom_range(1) ? -(longint'(step_max) * n / 2) : rand32();
        v = rand32();
        for (k = 0; k < n; k++) begin
            push_load(k, t, v);
            t = sat32(t + (($urandom_range(9) == 0) ? 0 : longint'($urandom_range(step_max))));
            if ($urandom_range(3) == 0) begin
                v = rand32();
            end else begin
                v = sat32(v + longint'($urandom_range(1 << 21)) - (1 << 20));
            end
        end
    endtask

    task automatic run_phase(int c, int items);
        int n;
        int made;
        int pick;
        write_count(c);
        n = eff_count(c);
        push_sorted_table(n);
        made = n;
        while (made < items) begin
            pick = $urandom_range(99);
            if (pick < 6 && made + n <= items) begin
                push_sorted_table(n);
                made += n;
            end else if (pick < 20) begin
                push_load($urandom_range(TABLE_DEPTH - 1), rand32(), rand32());
                made++;
            end else begin
                push_query(pick_query(n));
                made++;
            end
        end
    endtask

    initial begin
        int k;
        int c;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every table entry so no query reads an unwritten one
        for (k = 0; k < TABLE_DEPTH; k++) begin
            push_load(k, rand32(), rand32());
        end

        // directed: reset point count, extremes, slopes, zero-length and unsorted
        push_load(0, 0, 0);
        push_load(1, ONE, VAL_MAX);
        push_query(ONE / 2);
        push_query(VAL_MIN);
        push_query(VAL_MAX);
        push_load(0, VAL_MIN, VAL_MIN);
        push_load(1, VAL_MAX, VAL_MAX);
        push_query(0);
        push_query(VAL_MIN);
        push_query(VAL_MAX);
        push_load(1, VAL_MIN, 5);
        push_query(0);
        push_query(VAL_MIN);
        push_load(1, VAL_MAX, VAL_MIN);
        push_query(VAL_MAX);
        push_query(0);
        push_load(0, VAL_MAX, 0);
        push_load(1, VAL_MIN, VAL_MAX);
        push_query(0);
        push_query(VAL_MAX);
        push_query(VAL_MIN);

        // random phases over point count settings, out-of-range ones included
        for (k = 0; k < PHASE_NUM; k++) begin
            case (k)
                0: c = TABLE_DEPTH;
                1: c = 0;
                2: c = 1;
                3: c = (1 << CNT_W) - 1;
                4: c = TABLE_DEPTH + 1;
                5: c = 3;
                6, 7: c = $urandom_range(TABLE_DEPTH, 2);
                8, 9: c = $urandom_range((1 << CNT_W) - 1, 0);
                default: c = 2;
            endcase
            run_phase(c, PHASE_ITEMS);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS piecewise_linear_table_interp");
        end else begin
            $display("FAIL piecewise_linear_table_interp");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/plti_pkg.sv
rtl/plti_div.sv
rtl/plti_dpath.sv
rtl/plti_ctrl.sv
rtl/piecewise_linear_table_interp.sv
test/tb.sv
